### hdl/dda_pkg.sv
// Package for the three-axis DDA step queue: modes, register indexes, widths.
// No dependencies.
`timescale 1ns / 1ps
package dda_pkg;
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_QUEUE = 2'd1,
    MODE_SETPOS = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  localparam logic [0:0] REG_AXIS_INVERT = 1'b0;
  localparam logic [0:0] REG_ACTIVE_LOW = 1'b1;
  localparam logic [31:0] RESET_INTERVAL = 32'd2500;

  typedef struct packed {
    logic [1:0] mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [31:0] interval;
    logic [5:0] switch_levels;
  } in_item_t;

  typedef struct packed {
    logic [2:0] step_pulses;
    logic [2:0] direction_pins;
    logic [2:0] enable_pins;
    logic [31:0] tick_interval;
    logic idle;
    logic rejected;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic [5:0] endstop_states;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] interval;
  } point_t;
endpackage

### hdl/dda_if.sv
// Valid/ready channel interface carrying one item of a given type.
// The payload type is a parameter; no dependencies.
`timescale 1ns / 1ps
interface dda_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/dda_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dda_ram #(
  parameter int Width = 128,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/three_axis_dda_step_queue.sv
// Top level of the three-axis DDA step queue.
// Depends on dda_pkg, dda_if and dda_ram.
`timescale 1ns / 1ps
// Usage: items come in on in_ch (mode, coords, interval, switch levels); each
// gives exactly one result on out_ch. Mode 1 queues a target point, mode 2
// loads position and target, mode 0 is one timer tick, mode 3 reports status.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// The result is registered first in the gen_q stage and then in the output
// register; a tick that reaches its target and pops a point passes the pop state first.
// Throughput: one item a cycle while the output is free, except that a tick landing on
// target with a point waiting is followed by the pop from the point RAM, with no transfer.
// The head point is kept prefetched in the RAM's read register; a queue write
// that changes the head entry refreshes it in the next cycle, during which
// no tick is taken.
// A skid of one output register lets the next item enter while a result
// waits; a stalled receiver holds in_ch.ready low once that register is full
// or about to fill.
// Reset: positions, targets and deltas zero, drivers disabled, interval 2500,
// queue empty and drained. The point store itself is not cleared.
module three_axis_dda_step_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  dda_if.sink         in_ch,
  dda_if.source       out_ch
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

  logic [2:0] inv_q;
  logic       act_low_q;

  logic [31:0] pos_q [3];
  logic [31:0] tgt_q [3];
  logic [32:0] mag_q [3];
  logic signed [33:0] err_q [3];
  logic [32:0] big_q;
  logic [2:0]  dir_q, en_q;
  logic [31:0] ivl_q;
  logic [AW-1:0] head_q, tail_q;
  logic [CW-1:0] cnt_q;
  logic        drained_q;
  logic        stale_q;   // RAM read register not yet showing head entry
  logic        pop_q;     // pop state: the popped point is loaded from the RAM read data

  dda_pkg::in_item_t  it;
  dda_pkg::out_item_t res_q, skid_q, res_d;
  logic res_v_q, skid_v_q;
  logic gen_q;   // a result is due this cycle from state

  logic [127:0] rd;
  dda_pkg::point_t pt;
  assign pt = dda_pkg::point_t'(rd);

  assign it = in_ch.data;

  // Config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= '0;
      act_low_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dda_pkg::REG_AXIS_INVERT: inv_q <= cfg_data_i;
        dda_pkg::REG_ACTIVE_LOW:  act_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic out_free;
  assign out_free = !skid_v_q && !(gen_q && res_v_q && !out_ch.ready);
  logic is_tick;
  assign is_tick = it.mode == dda_pkg::MODE_TICK;
  assign in_ch.ready = out_free && !pop_q && !(stale_q && is_tick);
  logic acc;
  assign acc = in_ch.valid && in_ch.ready;

  logic [5:0] act;
  assign act = act_low_q ? ~it.switch_levels : it.switch_levels;

  // Tick datapath
  logic [2:0]  en_t, steps;
  logic [31:0] pos_t [3];
  logic signed [33:0] err_t [3];
  logic at_t;
  always_comb begin
    logic signed [33:0] e;
    e = '0;
    en_t = en_q;
    steps = '0;
    for (int a = 0; a < 3; a++) begin
      if (dir_q[a] ? act[2*a+1] : act[2*a]) en_t[a] = 1'b0;
      pos_t[a] = pos_q[a];
      err_t[a] = err_q[a];
      if (pos_q[a] != tgt_q[a]) begin
        e = err_q[a] + $signed({1'b0, mag_q[a]});
        err_t[a] = e;
        if (e > 0) begin
          steps[a] = 1'b1;
          err_t[a] = e - $signed({1'b0, big_q});
          pos_t[a] = dir_q[a] ? pos_q[a] + 32'd1 : pos_q[a] - 32'd1;
        end
      end
    end
    at_t = (pos_t[0] == tgt_q[0]) && (pos_t[1] == tgt_q[1]) && (pos_t[2] == tgt_q[2]);
  end

  // Pop datapath from RAM read data
  logic [31:0] pc [3];
  logic [32:0] pmag [3];
  logic [2:0]  pdir;
  logic [32:0] pbig;
  always_comb begin
    logic signed [32:0] d;
    pc[0] = pt.x; pc[1] = pt.y; pc[2] = pt.z;
    pbig = '0;
    for (int a = 0; a < 3; a++) begin
      d = $signed({pc[a][31], pc[a]}) - $signed({pos_q[a][31], pos_q[a]});
      pdir[a] = !d[32];
      pmag[a] = d[32] ? 33'(-d) : 33'(d);
    end
    pbig = pmag[0];
    if (pmag[1] > pbig) pbig = pmag[1];
    if (pmag[2] > pbig) pbig = pmag[2];
  end

  logic queue_w, pop_go;
  assign queue_w = acc && it.mode == dda_pkg::MODE_QUEUE && cnt_q != FullCnt;
  assign pop_go = acc && is_tick && at_t && cnt_q != '0;
  logic [AW-1:0] head_n;
  assign head_n = (head_q == LastIdx) ? '0 : head_q + AW'(1);

  // During a pop the next head is fetched so it is ready once the pop is done
  dda_ram #(.Width(128), .Depth(QUEUE_DEPTH)) u_ram (
    .clk_i,
    .we_i    (queue_w),
    .waddr_i (tail_q),
    .wdata_i ({it.coord_x, it.coord_y, it.coord_z, it.interval}),
    .raddr_i ((pop_q) ? head_n : head_q),
    .rdata_o (rd)
  );

  logic [2:0] steps_q;
  logic [5:0] act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        pos_q[a] <= '0; tgt_q[a] <= '0; mag_q[a] <= '0; err_q[a] <= '0;
      end
      big_q <= '0; dir_q <= '0; en_q <= '0;
      ivl_q <= dda_pkg::RESET_INTERVAL;
      head_q <= '0; tail_q <= '0; cnt_q <= '0;
      drained_q <= 1'b1; stale_q <= 1'b1; pop_q <= 1'b0;
      steps_q <= '0; act_q <= '0;
    end else begin
      stale_q <= 1'b0;
      if (pop_q) begin
        pop_q <= 1'b0;
        head_q <= head_n;
        cnt_q <= cnt_q - CW'(1);
        dir_q <= pdir;
        big_q <= pbig;
        for (int a = 0; a < 3; a++) begin
          tgt_q[a] <= pc[a];
          mag_q[a] <= pmag[a];
          err_q[a] <= -$signed({2'b00, pbig[32:1]});
        end
        en_q <= {pmag[2] != '0, en_q[1] | (pmag[1] != '0), en_q[0] | (pmag[0] != '0)};
        ivl_q <= pt.interval;
      end else if (acc) begin
        case (it.mode)
          dda_pkg::MODE_TICK: begin
            en_q <= en_t;
            for (int a = 0; a < 3; a++) begin
              pos_q[a] <= pos_t[a]; err_q[a] <= err_t[a];
            end
            if (at_t && cnt_q == '0) drained_q <= 1'b1;
            pop_q <= pop_go;
            steps_q <= steps;
            act_q <= act;
          end
          dda_pkg::MODE_QUEUE: begin
            if (queue_w) begin
              tail_q <= (tail_q == LastIdx) ? '0 : tail_q + AW'(1);
              cnt_q <= cnt_q + CW'(1);
              drained_q <= 1'b0;
              if (tail_q == head_q) stale_q <= 1'b1;
            end
          end
          dda_pkg::MODE_SETPOS: begin
            pos_q[0] <= it.coord_x; tgt_q[0] <= it.coord_x;
            pos_q[1] <= it.coord_y; tgt_q[1] <= it.coord_y;
            pos_q[2] <= it.coord_z; tgt_q[2] <= it.coord_z;
          end
          default: ;
        endcase
      end
    end
  end

  // Result built from updated state
  logic at_now;
  assign at_now = (pos_q[0] == tgt_q[0]) && (pos_q[1] == tgt_q[1]) && (pos_q[2] == tgt_q[2]);
  logic [2:0] st_d;
  logic [5:0] ac_d;
  logic rej_d;
  always_comb begin
    st_d = pop_q ? steps_q : ((acc && is_tick) ? steps : '0);
    ac_d = pop_q ? act_q : act;
    rej_d = acc && it.mode == dda_pkg::MODE_QUEUE && cnt_q == FullCnt;
  end

  // Result fields are registered alongside the state update, so use a stage.
  logic [2:0]  gst_q;
  logic [5:0]  gac_q;
  logic        grej_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= 1'b0; gst_q <= '0; gac_q <= '0; grej_q <= 1'b0;
    end else begin
      gen_q <= (acc && !pop_go) || pop_q;
      gst_q <= st_d;
      gac_q <= ac_d;
      grej_q <= rej_d;
    end
  end

  always_comb begin
    res_d.step_pulses = gst_q;
    res_d.direction_pins = dir_q ^ inv_q;
    res_d.enable_pins = en_q;
    res_d.tick_interval = ivl_q;
    res_d.idle = drained_q && at_now;
    res_d.rejected = grej_q;
    res_d.position_x = pos_q[0];
    res_d.position_y = pos_q[1];
    res_d.position_z = pos_q[2];
    res_d.endstop_states = gac_q;
  end

  // Output register plus skid: gen_q may arrive while out is stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0; skid_v_q <= 1'b0;
    end else begin
      if (!res_v_q || out_ch.ready) begin
        if (skid_v_q) begin
          res_v_q <= 1'b1; skid_v_q <= gen_q;
        end else begin
          res_v_q <= gen_q;
        end
      end else if (gen_q) begin
        skid_v_q <= 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (!res_v_q || out_ch.ready) begin
      res_q <= skid_v_q ? skid_q : res_d;
      if (skid_v_q) skid_q <= res_d;
    end else if (gen_q) begin
      skid_q <= res_d;
    end
  end

  assign out_ch.valid = res_v_q;
  assign out_ch.data = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= FullCnt)
    else $error("queue count overflow");
  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_q |=> !pop_q)
    else $error("pop lasted more than one cycle");
  a_no_in_pop: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_q |-> !acc)
    else $error("transfer during pop");
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> res_v_q)
    else $error("skid full with empty output");
endmodule

### tb/sv/dda_step_checker.sv
// Checker for the three-axis DDA step queue: watches both channels, predicts
// each result from its own copy of the block state and compares field by field.
// Depends on dda_pkg.
`timescale 1ns / 1ps
module dda_step_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  dda_pkg::in_item_t  in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  dda_pkg::out_item_t out_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_seen_o
);
  logic [2:0]         inv_q;
  logic               act_low_q;
  logic [31:0]        pos_q [3];
  logic [31:0]        tgt_q [3];
  logic [32:0]        mag_q [3];
  logic signed [33:0] err_q [3];
  logic [32:0]        big_q;
  logic [2:0]         dir_q;
  logic [2:0]         en_q;
  logic [31:0]        ival_q;
  dda_pkg::point_t    fifo_q [$];
  logic               drained_q;
  dda_pkg::out_item_t want_q [$];

  assign pending_o = want_q.size();

  function automatic logic on_tgt();
    return pos_q[0] == tgt_q[0] && pos_q[1] == tgt_q[1] && pos_q[2] == tgt_q[2];
  endfunction

  task automatic take_point();
    dda_pkg::point_t p;
    logic [31:0] c [3];
    logic signed [33:0] d;
    if (fifo_q.size() == 0) begin
      drained_q = 1'b1;
      return;
    end
    p = fifo_q.pop_front();
    c[0] = p.x; c[1] = p.y; c[2] = p.z;
    dir_q = '0;
    big_q = '0;
    for (int a = 0; a < 3; a++) begin
      tgt_q[a] = c[a];
      d = $signed({{2{c[a][31]}}, c[a]}) - $signed({{2{pos_q[a][31]}}, pos_q[a]});
      if (d >= 0) begin
        dir_q[a] = 1'b1;
        mag_q[a] = d[32:0];
      end else begin
        mag_q[a] = 33'(-d);
      end
      if (mag_q[a] > big_q) big_q = mag_q[a];
    end
    if (mag_q[0] != 0) en_q[0] = 1'b1;
    if (mag_q[1] != 0) en_q[1] = 1'b1;
    en_q[2] = mag_q[2] != 0;
    for (int a = 0; a < 3; a++) err_q[a] = -$signed({1'b0, big_q >> 1});
    ival_q = p.interval;
  endtask

  task automatic predict_item(input dda_pkg::in_item_t it);
    dda_pkg::out_item_t o;
    logic [5:0] act;
    logic [2:0] steps;
    logic rej;
    dda_pkg::point_t p;
    act = act_low_q ? ~it.switch_levels : it.switch_levels;
    steps = '0;
    rej = 1'b0;
    case (dda_pkg::mode_e'(it.mode))
      dda_pkg::MODE_TICK: begin
        for (int a = 0; a < 3; a++)
          if (dir_q[a] ? act[2*a+1] : act[2*a]) en_q[a] = 1'b0;
        for (int a = 0; a < 3; a++) begin
          if (pos_q[a] != tgt_q[a]) begin
            err_q[a] = err_q[a] + $signed({1'b0, mag_q[a]});
            if (err_q[a] > 0) begin
              steps[a] = 1'b1;
              err_q[a] = err_q[a] - $signed({1'b0, big_q});
              pos_q[a] = dir_q[a] ? pos_q[a] + 32'd1 : pos_q[a] - 32'd1;
            end
          end
        end
        if (on_tgt()) take_point();
      end
      dda_pkg::MODE_QUEUE: begin
        if (fifo_q.size() >= QUEUE_DEPTH) begin
          rej = 1'b1;
        end else begin
          p.x = it.coord_x; p.y = it.coord_y; p.z = it.coord_z;
          p.interval = it.interval;
          fifo_q.push_back(p);
          drained_q = 1'b0;
        end
      end
      dda_pkg::MODE_SETPOS: begin
        pos_q[0] = it.coord_x; tgt_q[0] = it.coord_x;
        pos_q[1] = it.coord_y; tgt_q[1] = it.coord_y;
        pos_q[2] = it.coord_z; tgt_q[2] = it.coord_z;
      end
      default: ;
    endcase
    o.step_pulses = steps;
    o.direction_pins = dir_q ^ inv_q;
    o.enable_pins = en_q;
    o.tick_interval = ival_q;
    o.idle = drained_q && on_tgt();
    o.rejected = rej;
    o.position_x = pos_q[0];
    o.position_y = pos_q[1];
    o.position_z = pos_q[2];
    o.endstop_states = act;
    want_q.push_back(o);
  endtask

  task automatic note_miss(input string what, input logic [31:0] e, input logic [31:0] g);
    if (fail_count_o < 10)
      $display("mismatch %s: expected %h got %h", what, e, g);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dda_pkg::out_item_t w;
    if (!rst_ni) begin
      inv_q <= '0; act_low_q <= '0;
      for (int a = 0; a < 3; a++) begin
        pos_q[a] = '0; tgt_q[a] = '0; mag_q[a] = '0; err_q[a] = '0;
      end
      big_q = '0; dir_q = '0; en_q = '0; ival_q = dda_pkg::RESET_INTERVAL;
      fifo_q.delete(); want_q.delete(); drained_q = 1'b1;
      fail_count_o = 0; results_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (want_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %h", out_data_i);
          fail_count_o++;
        end else begin
          w = want_q.pop_front();
          if (w.step_pulses != out_data_i.step_pulses)
            note_miss("step_pulses", 32'(w.step_pulses), 32'(out_data_i.step_pulses));
          if (w.direction_pins != out_data_i.direction_pins)
            note_miss("direction_pins", 32'(w.direction_pins),
                      32'(out_data_i.direction_pins));
          if (w.enable_pins != out_data_i.enable_pins)
            note_miss("enable_pins", 32'(w.enable_pins), 32'(out_data_i.enable_pins));
          if (w.tick_interval != out_data_i.tick_interval)
            note_miss("tick_interval", w.tick_interval, out_data_i.tick_interval);
          if (w.idle != out_data_i.idle)
            note_miss("idle", 32'(w.idle), 32'(out_data_i.idle));
          if (w.rejected != out_data_i.rejected)
            note_miss("rejected", 32'(w.rejected), 32'(out_data_i.rejected));
          if (w.position_x != out_data_i.position_x)
            note_miss("position_x", w.position_x, out_data_i.position_x);
          if (w.position_y != out_data_i.position_y)
            note_miss("position_y", w.position_y, out_data_i.position_y);
          if (w.position_z != out_data_i.position_z)
            note_miss("position_z", w.position_z, out_data_i.position_z);
          if (w.endstop_states != out_data_i.endstop_states)
            note_miss("endstop_states", 32'(w.endstop_states),
                      32'(out_data_i.endstop_states));
        end
      end
      if (in_valid_i && in_ready_i) predict_item(in_data_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == dda_pkg::REG_AXIS_INVERT) inv_q <= cfg_data_i;
        else act_low_q <= cfg_data_i[0];
      end
    end
  end
endmodule

### tb/sv/three_axis_dda_step_queue_tb.sv
// Testbench top for the three-axis DDA step queue: drives items with bursty
// gaps, stalls the receiver, walks the registers and reports the verdict.
// Depends on dda_pkg, dda_if, the block and dda_step_checker.
`timescale 1ns / 1ps
module three_axis_dda_step_queue_tb;
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [2:0] cfg_data_i = '0;
  int         fail_count;
  int         pending;
  int         results_seen;
  int         idle_cycles = 0;
  int         sent = 0;
  int         ticks_sent = 0;
  bit         long_hold = 1'b0;
  bit         stall_on = 1'b0;

  dda_if #(.T(dda_pkg::in_item_t))  in_ch ();
  dda_if #(.T(dda_pkg::out_item_t)) out_ch ();

  always #1 clk_i = ~clk_i;

  three_axis_dda_step_queue u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  dda_step_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_data_i(in_ch.data),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // receiver: random stalls, long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni || long_hold) out_ch.ready <= 1'b0;
    else if (stall_on) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready))
      idle_cycles <= idle_cycles + 1;
    else idle_cycles <= 0;
    if (idle_cycles > 20000) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord(input logic [31:0] base);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return base + 32'($signed($urandom_range(0, 40)) - 20);
    endcase
  endfunction

  task automatic send_item(input dda_pkg::in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
    if (it.mode == dda_pkg::MODE_TICK) ticks_sent++;
  endtask

  task automatic gap_maybe(inout int burst);
    if (burst > 0) begin
      burst--;
      return;
    end
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    burst = $urandom_range(0, 12);
  endtask

  task automatic make_item(input dda_pkg::mode_e m, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z,
                           input logic [31:0] iv, output dda_pkg::in_item_t it);
    it.mode = m; it.coord_x = x; it.coord_y = y; it.coord_z = z;
    it.interval = iv;
    it.switch_levels = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : '0;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [2:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    dda_pkg::in_item_t it;
    int burst;
    logic [31:0] bx, by, bz;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every mode, full queue, wrap, empty-at-target tick
    stall_on = 1'b0;
    make_item(dda_pkg::MODE_TICK, 0, 0, 0, 0, it); send_item(it);
    make_item(dda_pkg::MODE_NONE, '1, '1, '1, '1, it); it.switch_levels = '1; send_item(it);
    make_item(dda_pkg::MODE_SETPOS, 32'h7fff_fffe, 32'h8000_0001, 0, 0, it); send_item(it);
    make_item(dda_pkg::MODE_QUEUE, 32'h8000_0000, 32'h7fff_ffff, 3, 32'hffff_ffff, it);
    send_item(it);
    for (int i = 0; i < 16; i++) begin
      make_item(dda_pkg::MODE_QUEUE, 32'h7fff_ffff - i, 32'h8000_0000 + i, -i, i, it);
      send_item(it);
    end
    for (int i = 0; i < 6; i++) begin
      make_item(dda_pkg::MODE_TICK, 0, 0, 0, 0, it);
      it.switch_levels = 6'(1 << i);
      send_item(it);
    end
    wait_drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(dda_pkg::REG_AXIS_INVERT,
                (phase == 0) ? 3'd7 : (phase == 1) ? 3'd0 : 3'($urandom()));
      write_reg(dda_pkg::REG_ACTIVE_LOW, phase[0] ? 3'd1 : 3'd0);
      stall_on = phase != 2;
      make_item(dda_pkg::MODE_SETPOS, $urandom(), $urandom(), $urandom(), 0, it);
      it.switch_levels = phase[0] ? '1 : '0;
      send_item(it);
      bx = it.coord_x; by = it.coord_y; bz = it.coord_z;
      burst = $urandom_range(0, 12);
      for (int n = 0; n < 155; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: begin
            bx = pick_coord(bx); by = pick_coord(by); bz = pick_coord(bz);
            if (bx[31] ^ bx[30]) bx = $urandom_range(0, 30);
            make_item(dda_pkg::MODE_QUEUE, bx, by, bz, $urandom(), it);
          end
          4: make_item(dda_pkg::MODE_SETPOS, $urandom_range(0, 50), $urandom(),
                       $urandom_range(0, 50), $urandom(), it);
          5: make_item(dda_pkg::MODE_NONE, $urandom(), $urandom(), $urandom(),
                       $urandom(), it);
          default: make_item(dda_pkg::MODE_TICK, $urandom(), $urandom(), $urandom(),
                             $urandom(), it);
        endcase
        if (phase[0]) it.switch_levels = ~it.switch_levels;
        send_item(it);
        if (phase == 3 && n == 60) begin
          long_hold = 1'b1;
          fork
            begin
              repeat (300) @(posedge clk_i);
              long_hold = 1'b0;
            end
          join_none
        end
        if (phase == 4 && n == 80) wait_drain();
        gap_maybe(burst);
      end
      wait_drain();
    end

    repeat (10) @(posedge clk_i);
    $display("covered %0d items (%0d ticks) over six register settings, %0d results",
             sent, ticks_sent, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
